// ----- hdl/pngunf_pkg.sv -----
`default_nettype none

package pngunf_pkg;

  // Widths of the configuration registers and of the port fields.
  localparam int ROW_BYTES_W   = 15;
  localparam int BPP_W         = 4;
  localparam int ROW_COUNT_W   = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 31;
  localparam int BYTE_W        = 8;

  // Default sizing of the prior-row store and the left-neighbor windows.
  localparam int MAX_ROW_BYTES_DEF   = 16384;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  // Highest legal filter type code.
  localparam logic [BYTE_W-1:0] FILTER_MAX_CODE = 8'd4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_BYTES = 2'd0,
    CFG_BPP       = 2'd1,
    CFG_ROW_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

endpackage

`default_nettype wire

// ----- hdl/png_scanline_unfilter_top.sv -----
`default_nettype none

// PNG scanline unfilter: takes the inflated stream one byte per item and returns one
// reconstructed byte per data byte, one item per clock in steady state while the output
// is not stalled. Each row starts with a filter type byte, which gives no result unless
// it is invalid, in which case an error result (status 1) is returned and the row is
// passed through as None. An item is registered in the input stage, where the byte above
// is read from the prior-row RAM, and is then reconstructed into the output register;
// the one-byte dependency on the left neighbor is closed in that second stage, which
// sets the rate of one byte per cycle. The prior-row RAM holds MAX_ROW_BYTES bytes and
// needs no clearing after reset: the first row of each image uses zeros instead.
// Configuration may only be written while no item is in flight.
module png_scanline_unfilter_top #(
  parameter int MAX_ROW_BYTES   = pngunf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pngunf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,

  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pngunf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_data,

  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        stream_byte,

  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [7:0]                        pixel_byte,
  output logic                                   status,
  output logic                                   end_of_row,
  output logic                                   end_of_image
);

  localparam int COL_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int WIN_W = 8 * MAX_PIXEL_BYTES;

  typedef enum logic [1:0] {
    KIND_FILTER,
    KIND_BAD_FILTER,
    KIND_DATA
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    pngunf_pkg::filter_t filter;
    logic                first_row;
    logic                has_left;
    logic                last_row;
    logic                last_image;
  } stage_ctl_t;

  // Configuration registers.
  logic [pngunf_pkg::ROW_BYTES_W-1:0] row_bytes;
  logic [pngunf_pkg::BPP_W-1:0]       bytes_per_pixel;
  logic [pngunf_pkg::ROW_COUNT_W-1:0] row_count;

  logic [31:0]                        rb_eff;
  logic [pngunf_pkg::BPP_W-1:0]       bpp_eff;
  logic [pngunf_pkg::ROW_COUNT_W-1:0] rc_eff;

  // Row tracking at the input.
  logic [COL_W-1:0]                   column;
  logic [COL_W-1:0]                   column_next;
  logic [pngunf_pkg::ROW_COUNT_W-1:0] row_index;
  logic [pngunf_pkg::ROW_COUNT_W-1:0] row_index_next;
  logic [pngunf_pkg::ROW_COUNT_W-1:0] row_index_inc;
  pngunf_pkg::filter_t                current_filter;
  pngunf_pkg::filter_t                current_filter_next;

  logic       in_accept;
  logic       is_filter_byte;
  logic       bad_filter;
  logic       last_row;
  logic       last_image;
  stage_ctl_t ctl_in;

  // Input stage.
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic [ADDR_W-1:0] s1_addr;
  stage_ctl_t        s1_ctl;
  logic              s1_has_result;
  logic              s1_adv;
  logic              s1_is_data;

  logic [7:0]        prior_rd;
  logic [ADDR_W-1:0] rd_addr;

  // Neighbor windows, newest byte in the low lane.
  logic [WIN_W-1:0] left_window;
  logic [WIN_W-1:0] upleft_window;

  logic [7:0] a_byte;
  logic [7:0] b_byte;
  logic [7:0] c_byte;
  logic [7:0] val;

  logic out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= pngunf_pkg::ROW_BYTES_W'(1);
      bytes_per_pixel <= pngunf_pkg::BPP_W'(1);
      row_count       <= pngunf_pkg::ROW_COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pngunf_pkg::CFG_ROW_BYTES: row_bytes <= cfg_data[pngunf_pkg::ROW_BYTES_W-1:0];
        pngunf_pkg::CFG_BPP:       bytes_per_pixel <= cfg_data[pngunf_pkg::BPP_W-1:0];
        pngunf_pkg::CFG_ROW_COUNT: row_count <= cfg_data[pngunf_pkg::ROW_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = 32'd1;
    end else if (32'(row_bytes) > 32'(MAX_ROW_BYTES)) begin
      rb_eff = 32'(MAX_ROW_BYTES);
    end else begin
      rb_eff = 32'(row_bytes);
    end

    if (bytes_per_pixel == '0) begin
      bpp_eff = pngunf_pkg::BPP_W'(1);
    end else if (32'(bytes_per_pixel) > 32'(MAX_PIXEL_BYTES)) begin
      bpp_eff = pngunf_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bytes_per_pixel;
    end

    rc_eff = (row_count == '0) ? pngunf_pkg::ROW_COUNT_W'(1) : row_count;
  end

  // Input side: classify the byte and advance the row position.
  assign in_accept      = in_valid && !in_stall;
  assign is_filter_byte = (column == '0);
  assign bad_filter     = stream_byte > pngunf_pkg::FILTER_MAX_CODE;
  assign last_row       = 32'(column) >= rb_eff;
  assign row_index_inc  = row_index + pngunf_pkg::ROW_COUNT_W'(1);
  assign last_image     = last_row && (row_index_inc >= rc_eff);
  assign rd_addr        = ADDR_W'(column - COL_W'(1));

  always_comb begin
    column_next         = column;
    row_index_next      = row_index;
    current_filter_next = current_filter;
    if (is_filter_byte) begin
      column_next         = COL_W'(1);
      current_filter_next = bad_filter ? pngunf_pkg::FILT_NONE
                                       : pngunf_pkg::filter_t'(stream_byte[2:0]);
    end else if (last_row) begin
      column_next    = '0;
      row_index_next = last_image ? '0 : row_index_inc;
    end else begin
      column_next = column + COL_W'(1);
    end
  end

  always_comb begin
    ctl_in.kind       = is_filter_byte ? (bad_filter ? KIND_BAD_FILTER : KIND_FILTER)
                                       : KIND_DATA;
    ctl_in.filter     = current_filter;
    ctl_in.first_row  = (row_index == '0);
    ctl_in.has_left   = 32'(column) > 32'(bpp_eff);
    ctl_in.last_row   = !is_filter_byte && last_row;
    ctl_in.last_image = !is_filter_byte && last_image;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      row_index      <= '0;
      current_filter <= pngunf_pkg::FILT_NONE;
    end else if (in_accept) begin
      column         <= column_next;
      row_index      <= row_index_next;
      current_filter <= current_filter_next;
    end
  end

  // Input stage register; the prior-row read lands alongside it.
  assign s1_has_result = s1_ctl.kind != KIND_FILTER;
  assign s1_is_data    = s1_ctl.kind == KIND_DATA;
  assign out_take      = out_valid && !out_stall;
  assign s1_adv        = s1_valid && (!s1_has_result || !out_valid || out_take);
  assign in_stall      = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= stream_byte;
      s1_addr <= rd_addr;
      s1_ctl  <= ctl_in;
    end
  end

  // The write of byte i and the read for the following item can share an address only if
  // that item is a filter byte, whose read is not used; a following data byte reads i+1.
  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_prior_row (
    .clk     (clk),
    .wr_en   (s1_adv && s1_is_data),
    .wr_addr (s1_addr),
    .wr_data (val),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (prior_rd)
  );

  assign b_byte = s1_ctl.first_row ? 8'd0 : prior_rd;
  assign a_byte = s1_ctl.has_left ? left_window[8*(32'(bpp_eff) - 1) +: 8] : 8'd0;
  assign c_byte = s1_ctl.has_left ? upleft_window[8*(32'(bpp_eff) - 1) +: 8] : 8'd0;

  pngunf_predict u_predict (
    .filter (s1_ctl.filter),
    .raw    (s1_byte),
    .a      (a_byte),
    .b      (b_byte),
    .c      (c_byte),
    .val    (val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_window   <= '0;
      upleft_window <= '0;
    end else if (s1_adv) begin
      if (s1_is_data) begin
        left_window   <= (left_window << 8) | WIN_W'(val);
        upleft_window <= (upleft_window << 8) | WIN_W'(b_byte);
      end else begin
        left_window   <= '0;
        upleft_window <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_has_result) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_result) begin
      pixel_byte   <= s1_is_data ? val : 8'd0;
      status       <= !s1_is_data;
      end_of_row   <= s1_ctl.last_row;
      end_of_image <= s1_ctl.last_image;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pngunf_ram.sv -----
`default_nettype none

module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pngunf_predict.sv -----
`default_nettype none

module pngunf_predict (
  input  wire pngunf_pkg::filter_t filter,
  input  wire logic [7:0]          raw,
  input  wire logic [7:0]          a,
  input  wire logic [7:0]          b,
  input  wire logic [7:0]          c,
  output logic      [7:0]          val
);

  logic [8:0] sum_ab9;
  logic [7:0] avg;
  logic [7:0] pa;
  logic [7:0] pb;
  logic [9:0] sum_ab10;
  logic [9:0] c_twice;
  logic [9:0] pc;
  logic [7:0] paeth;
  logic [7:0] pred;

  assign sum_ab9 = {1'b0, a} + {1'b0, b};
  assign avg     = sum_ab9[8:1];

  // With p = a + b - c the three Paeth distances reduce to these forms.
  assign pa       = (b >= c) ? (b - c) : (c - b);
  assign pb       = (a >= c) ? (a - c) : (c - a);
  assign sum_ab10 = {2'b00, a} + {2'b00, b};
  assign c_twice  = {1'b0, c, 1'b0};
  assign pc       = (sum_ab10 >= c_twice) ? (sum_ab10 - c_twice) : (c_twice - sum_ab10);

  always_comb begin
    if (({2'b00, pa} <= {2'b00, pb}) && ({2'b00, pa} <= pc)) begin
      paeth = a;
    end else if ({2'b00, pb} <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  always_comb begin
    unique case (filter)
      pngunf_pkg::FILT_SUB:   pred = a;
      pngunf_pkg::FILT_UP:    pred = b;
      pngunf_pkg::FILT_AVG:   pred = avg;
      pngunf_pkg::FILT_PAETH: pred = paeth;
      default:                pred = 8'd0;
    endcase
  end

  assign val = raw + pred;

endmodule

`default_nettype wire

// ----- hdl/pngunf_checker.sv -----
`default_nettype none

module pngunf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] pixel_byte,
  input wire logic       status,
  input wire logic       end_of_row,
  input wire logic       end_of_image
);

  // A held result must not move.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_byte) && $stable(status)
      && $stable(end_of_row) && $stable(end_of_image))
    else $error("result changed while stalled");

  // An error result carries no pixel and no row or image marks.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (pixel_byte == 8'd0) && !end_of_row && !end_of_image)
    else $error("error result carries data");

  // The last byte of an image is always the last byte of a row.
  a_eoi_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_image |-> end_of_row)
    else $error("end of image without end of row");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind png_scanline_unfilter_top pngunf_checker u_pngunf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_byte   (pixel_byte),
  .status       (status),
  .end_of_row   (end_of_row),
  .end_of_image (end_of_image)
);

`default_nettype wire
